>>> design/ple_pkg.sv
// Shared types and codes for the positional list engine.
// Used by ple_cell and positional_list_engine_top; no dependencies.
package ple_pkg;

    // Fixed field widths of the request and result transfers
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;

    // Widest internal buses, sized for the largest supported build
    localparam int IDX_MAX_W  = 8;   // cell index, up to 256 cells
    localparam int CNT_MAX_W  = 9;   // list length, up to 256
    localparam int DATA_MAX_W = 64;  // stored word

    // Request kinds
    localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_LOCATE = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_GET    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

    // Result status
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // Cell update codes
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_DELETE = 2'd2;

    // Probe kinds
    localparam logic PROBE_INDEX  = 1'b0;
    localparam logic PROBE_LOCATE = 1'b1;

    // Command broadcast to every cell
    typedef struct packed {
        logic [1:0]            op;
        logic                  kind;
        logic [IDX_MAX_W-1:0]  idx;
        logic [CNT_MAX_W-1:0]  len;
        logic [DATA_MAX_W-1:0] value;
    } cell_cmd_t;

    // Search token handed from cell to cell
    typedef struct packed {
        logic                  valid;
        logic                  hit;
        logic [POS_W-1:0]      found;
        logic [DATA_MAX_W-1:0] data;
    } probe_t;

endpackage

>>> design/ple_cell.sv
// One list cell: holds a single entry and one stage of the search chain.
// Depends on ple_pkg for the command and probe types.
module ple_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ple_pkg::cell_cmd_t    cmd,
    input  logic [DATA_WIDTH-1:0] prev_entry,
    input  logic [DATA_WIDTH-1:0] next_entry,
    output logic [DATA_WIDTH-1:0] entry,
    input  ple_pkg::probe_t       probe_in,
    output ple_pkg::probe_t       probe_out
);
    import ple_pkg::*;

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    probe_t                probe_reg;
    probe_t                probe_next;
    logic                  at_idx;
    logic                  past_idx;
    logic                  match;

    assign at_idx   = (cmd.idx == IDX_MAX_W'(INDEX));
    assign past_idx = (IDX_MAX_W'(INDEX) > cmd.idx);

    // Entry update: insert pulls from the left, delete from the right
    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (at_idx)
                    entry_next = cmd.value[DATA_WIDTH-1:0];
                else if (past_idx)
                    entry_next = prev_entry;
            end
            CELL_DELETE:
            begin
                if (at_idx || past_idx)
                    entry_next = next_entry;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    // Match test for the passing probe
    always_comb
    begin
        if (cmd.kind == PROBE_LOCATE)
            match = (CNT_MAX_W'(INDEX) < cmd.len) &&
                    (entry_reg == cmd.value[DATA_WIDTH-1:0]);
        else
            match = at_idx;
    end

    // First hit along the chain wins; later cells pass it on
    always_comb
    begin
        probe_next = probe_in;
        if (probe_in.valid && !probe_in.hit && match)
        begin
            probe_next.hit   = 1'b1;
            probe_next.found = POS_W'(INDEX + 1);
            probe_next.data  = DATA_MAX_W'(entry_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // Probe stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            probe_reg <= '0;
        else
            probe_reg <= probe_next;
    end

    assign entry     = entry_reg;
    assign probe_out = probe_reg;

endmodule

>>> design/positional_list_engine_top.sv
// Top level of the positional list engine: control, length counter, cell chain.
// Depends on ple_pkg and ple_cell.
//
// Ordered list of up to CAPACITY words held in a row of cells, one entry each.
// Insert, clear, undefined actions and any rejected request go from idle
// straight to the done state, where their result is loaded into the output
// register. Locate, and get or delete at a valid position, send a search token
// down the cell chain one cell per cycle; the result is formed when the token
// leaves the last cell, and a delete closes the gap at that point. One request
// is in work at a time. The output register holds a finished result until it is
// taken, and a new request is taken meanwhile; its result then waits, and no
// further request is taken, until the output register is free. Stored words are
// the low DATA_WIDTH bits of the value; cells beyond the length hold whatever
// they last held.
module positional_list_engine_top #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [4:0] position, [36:5] value, [39:37] zero
    input  logic [2:0]  s_tuser,   // [2:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [31:0] data_out, [36:32] found_position,
                                   // [41:37] list_length, [42] list_empty,
                                   // [44:43] status, [47:45] zero
);
    import ple_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int OUT_W = VALUE_W + 2 * POS_W + 1 + STATUS_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  launch_reg, launch_next;
    logic                  out_valid_reg, out_valid_next;

    logic [ACTION_W-1:0]   req_action_reg;
    logic                  req_kind_reg;
    logic [IDX_MAX_W-1:0]  req_idx_reg;
    logic [DATA_MAX_W-1:0] req_val_reg;

    logic [VALUE_W-1:0]    res_data_reg, res_data_next;
    logic [POS_W-1:0]      res_found_reg, res_found_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [OUT_W-1:0]      out_reg;

    logic [POS_W-1:0]      in_pos;
    logic [VALUE_W-1:0]    in_val;
    logic [ACTION_W-1:0]   in_action;
    logic                  accept;
    logic                  pos_zero;
    logic                  ins_pos_ok;
    logic                  idx_pos_ok;
    logic                  full;
    logic                  probe_start;
    logic                  probe_kind;
    logic                  probe_done;
    logic                  out_free;
    logic [CMP_W-1:0]      pos_c;
    logic [CMP_W-1:0]      cnt_c;

    cell_cmd_t             cmd;
    probe_t                probe_chain [CAPACITY+1];
    logic [DATA_WIDTH-1:0] ent [CAPACITY];

    // Request fields
    assign in_pos    = s_tdata[POS_W-1:0];
    assign in_val    = s_tdata[POS_W+VALUE_W-1:POS_W];
    assign in_action = s_tuser;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Range checks on the request position
    assign pos_c      = CMP_W'(in_pos);
    assign cnt_c      = CMP_W'(count_reg);
    assign pos_zero   = (in_pos == '0);
    assign full       = (count_reg == CNT_W'(CAPACITY));
    assign ins_pos_ok = !pos_zero && (pos_c <= cnt_c + CMP_W'(1));
    assign idx_pos_ok = !pos_zero && (pos_c <= cnt_c);

    // Which requests need a walk along the chain
    always_comb
    begin
        probe_start = 1'b0;
        probe_kind  = PROBE_INDEX;
        case (in_action)
            ACT_DELETE, ACT_GET:
            begin
                probe_start = idx_pos_ok;
            end
            ACT_LOCATE:
            begin
                probe_start = 1'b1;
                probe_kind  = PROBE_LOCATE;
            end
            default:
            begin
                probe_start = 1'b0;
            end
        endcase
    end

    assign probe_done = (state_reg == S_PROBE) && probe_chain[CAPACITY].valid;

    // Command to the cells
    always_comb
    begin
        cmd.op    = CELL_HOLD;
        cmd.kind  = req_kind_reg;
        cmd.len   = CNT_MAX_W'(count_reg);
        cmd.idx   = req_idx_reg;
        cmd.value = req_val_reg;
        if (state_reg == S_IDLE)
        begin
            cmd.idx   = IDX_MAX_W'(in_pos - POS_W'(1));
            cmd.value = DATA_MAX_W'(in_val);
            if (accept && in_action == ACT_INSERT && !full && ins_pos_ok)
                cmd.op = CELL_INSERT;
        end
        else if (probe_done && req_action_reg == ACT_DELETE)
        begin
            cmd.op = CELL_DELETE;
        end
    end

    // Sequencer and result formation
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        launch_next     = 1'b0;
        out_valid_next  = out_valid_reg && !m_tready;
        res_data_next   = res_data_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_data_next   = '0;
                    res_found_next  = '0;
                    res_status_next = ST_OK;
                    if (probe_start)
                    begin
                        launch_next = 1'b1;
                        state_next  = S_PROBE;
                    end
                    else
                    begin
                        state_next = S_DONE;
                        case (in_action)
                            ACT_INSERT:
                            begin
                                if (full)
                                    res_status_next = ST_FULL;
                                else if (!ins_pos_ok)
                                    res_status_next = ST_RANGE;
                                else
                                    count_next = count_reg + CNT_W'(1);
                            end
                            ACT_DELETE, ACT_GET:
                            begin
                                res_status_next = ST_RANGE;
                            end
                            ACT_CLEAR:
                            begin
                                count_next = '0;
                            end
                            default:
                            begin
                                res_status_next = ST_OK;
                            end
                        endcase
                    end
                end
            end
            S_PROBE:
            begin
                if (probe_done)
                begin
                    state_next = S_DONE;
                    if (req_kind_reg == PROBE_LOCATE)
                    begin
                        res_data_next   = '0;
                        res_found_next  = probe_chain[CAPACITY].hit ?
                                          probe_chain[CAPACITY].found : '0;
                        res_status_next = probe_chain[CAPACITY].hit ? ST_OK : ST_NOTFOUND;
                    end
                    else
                    begin
                        res_data_next   = VALUE_W'(probe_chain[CAPACITY].data);
                        res_found_next  = '0;
                        res_status_next = ST_OK;
                        if (req_action_reg == ACT_DELETE)
                            count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            launch_reg    <= launch_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_action_reg <= in_action;
            req_kind_reg   <= probe_kind;
            req_idx_reg    <= IDX_MAX_W'(in_pos - POS_W'(1));
            req_val_reg    <= DATA_MAX_W'(in_val);
        end
        res_data_reg   <= res_data_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        if (state_reg == S_DONE && out_free)
            out_reg <= {res_status_reg, (count_reg == '0), POS_W'(count_reg),
                        res_found_reg, res_data_reg};
    end

    // Cell chain
    assign probe_chain[0] = '{valid: launch_reg, hit: 1'b0, found: '0, data: '0};

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (k == 0)
        begin : g_first
            assign left_w = cmd.value[DATA_WIDTH-1:0];
        end
        else
        begin : g_inner_l
            assign left_w = ent[k-1];
        end

        if (k == CAPACITY - 1)
        begin : g_last
            assign right_w = ent[k];
        end
        else
        begin : g_inner_r
            assign right_w = ent[k+1];
        end

        ple_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .prev_entry (left_w),
            .next_entry (right_w),
            .entry      (ent[k]),
            .probe_in   (probe_chain[k]),
            .probe_out  (probe_chain[k+1])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(48 - OUT_W){1'b0}}, out_reg};

endmodule
